// ===== src/pit_pkg.sv =====
// Package for the periodic interrupt timer: item codes, register selectors,
// control register bit layout and parameter defaults. No dependencies.
`default_nettype none

package pit_pkg;

  // Field widths of one item
  localparam int FUNC_BITS = 2;
  localparam int SEL_BITS  = 3;
  localparam int DATA_BITS = 32;

  // Parameter defaults
  localparam int COUNT_BITS_DEFAULT    = 32;
  localparam int PRESCALE_BITS_DEFAULT = 12;

  // Item function codes
  localparam logic [FUNC_BITS-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd2;

  // Register selectors
  localparam logic [SEL_BITS-1:0] REG_CONTROL = 3'd0;
  localparam logic [SEL_BITS-1:0] REG_STATUS  = 3'd1;
  localparam logic [SEL_BITS-1:0] REG_RELOAD  = 3'd2;
  localparam logic [SEL_BITS-1:0] REG_COMPARE = 3'd3;
  localparam logic [SEL_BITS-1:0] REG_COUNTER = 3'd4;

  // Control register layout
  localparam int CTRL_BITS      = 26;
  localparam int CTRL_EN_BIT    = 0;
  localparam int CTRL_ENMOD_BIT = 1;
  localparam int CTRL_OCIEN_BIT = 2;
  localparam int CTRL_RLD_BIT   = 3;
  localparam int CTRL_PRE_LSB   = 4;
  localparam int CTRL_CLK_LSB   = 24;
  localparam int CTRL_CLK_BITS  = 2;

  // Status register layout
  localparam int STAT_FLAG_BIT = 0;

endpackage

`default_nettype wire

// ===== src/periodic_interrupt_timer.sv =====
// Periodic down-counting interrupt timer with compare, behind a small register file.
// Depends on pit_pkg for item codes, register selectors and control bit layout.
// The timer takes one item per clock cycle while in_ready is high: a clock tick,
// a register write or a register read. Every item yields exactly one result,
// read_data (the selected register on reads, zero otherwise) plus interrupt_request
// as it stands after the item. All state updates for an item happen in the cycle
// the item is accepted, so the next item sees them at once; the result lands in a
// single output register. in_ready is high whenever that register is empty or is
// being taken in the same cycle, so with out_ready held high the block sustains
// one item per cycle; out_valid is registered at acceptance.
// Control: bit 0 enable, bit 1 load-on-enable, bit 2 compare interrupt enable,
// bit 3 reload mode, bits 4 and up the prescaler (divide by value+1), bits
// 25:24 clock source (zero stops counting). Status bit 0 is the sticky compare
// flag, cleared by writing 1. The counter register is read-only.
`default_nettype none

module periodic_interrupt_timer #(
  parameter int COUNT_BITS    = pit_pkg::COUNT_BITS_DEFAULT,
  parameter int PRESCALE_BITS = pit_pkg::PRESCALE_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pit_pkg::FUNC_BITS-1:0]  func,
  input  logic [pit_pkg::SEL_BITS-1:0]   reg_select,
  input  logic [pit_pkg::DATA_BITS-1:0]  write_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pit_pkg::DATA_BITS-1:0]  read_data,
  output logic                           interrupt_request
);

  import pit_pkg::*;

  // Architectural state
  logic [CTRL_BITS-1:0]     control;
  logic                     compare_flag;
  logic [COUNT_BITS-1:0]    reload_value;
  logic [COUNT_BITS-1:0]    compare_value;
  logic [COUNT_BITS-1:0]    count_value;
  logic [PRESCALE_BITS-1:0] prescale_count;

  logic [CTRL_BITS-1:0]     control_next;
  logic                     compare_flag_next;
  logic [COUNT_BITS-1:0]    reload_value_next;
  logic [COUNT_BITS-1:0]    compare_value_next;
  logic [COUNT_BITS-1:0]    count_value_next;
  logic [PRESCALE_BITS-1:0] prescale_count_next;
  logic [DATA_BITS-1:0]     read_data_next;

  logic                     in_accept;
  logic [PRESCALE_BITS-1:0] prescale_limit;
  logic [COUNT_BITS-1:0]    restart_value;
  logic [COUNT_BITS-1:0]    count_stepped;
  logic [63:0]              write_wide;
  logic [63:0]              reload_wide;
  logic [63:0]              compare_wide;
  logic [63:0]              count_wide;

  // Take a new item whenever the result register is free or draining.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign prescale_limit = control[CTRL_PRE_LSB +: PRESCALE_BITS];
  assign restart_value  = control[CTRL_RLD_BIT] ? reload_value : '1;
  // At zero restart the period, else count down by one.
  assign count_stepped  = (count_value == '0) ? restart_value
                                              : count_value - COUNT_BITS'(1);

  // Width adapters between the 32-bit bus and the counter width.
  assign write_wide   = {32'd0, write_data};
  assign reload_wide  = 64'(reload_value);
  assign compare_wide = 64'(compare_value);
  assign count_wide   = 64'(count_value);

  always_comb begin
    control_next        = control;
    compare_flag_next   = compare_flag;
    reload_value_next   = reload_value;
    compare_value_next  = compare_value;
    count_value_next    = count_value;
    prescale_count_next = prescale_count;
    read_data_next      = '0;

    case (func)
      FUNC_TICK: begin
        // Count only while enabled and fed by a clock source.
        if (control[CTRL_EN_BIT] && (control[CTRL_CLK_LSB +: CTRL_CLK_BITS] != '0)) begin
          if (prescale_count != prescale_limit) begin
            prescale_count_next = prescale_count + PRESCALE_BITS'(1);
          end else begin
            prescale_count_next = '0;
            count_value_next    = count_stepped;
            if (count_stepped == compare_value) begin
              compare_flag_next = 1'b1;
            end
          end
        end
      end
      FUNC_WRITE: begin
        case (reg_select)
          REG_CONTROL: begin
            control_next = write_data[CTRL_BITS-1:0];
            // Enable rising edge: restart the prescaler, optionally reload.
            if (!control[CTRL_EN_BIT] && write_data[CTRL_EN_BIT]) begin
              prescale_count_next = '0;
              if (write_data[CTRL_ENMOD_BIT]) begin
                count_value_next = write_data[CTRL_RLD_BIT] ? reload_value : '1;
              end
            end
          end
          REG_STATUS: begin
            if (write_data[STAT_FLAG_BIT]) begin
              compare_flag_next = 1'b0;
            end
          end
          REG_RELOAD:  reload_value_next  = write_wide[COUNT_BITS-1:0];
          REG_COMPARE: compare_value_next = write_wide[COUNT_BITS-1:0];
          default: ;  // counter and unused selectors drop the write
        endcase
      end
      FUNC_READ: begin
        case (reg_select)
          REG_CONTROL: read_data_next = DATA_BITS'(control);
          REG_STATUS:  read_data_next = DATA_BITS'(compare_flag);
          REG_RELOAD:  read_data_next = reload_wide[DATA_BITS-1:0];
          REG_COMPARE: read_data_next = compare_wide[DATA_BITS-1:0];
          REG_COUNTER: read_data_next = count_wide[DATA_BITS-1:0];
          default:     read_data_next = '0;
        endcase
      end
      default: ;  // unused code: no effect, result reads zero
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      control        <= '0;
      compare_flag   <= 1'b0;
      reload_value   <= '1;
      compare_value  <= '0;
      count_value    <= '1;
      prescale_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_accept) begin
        control        <= control_next;
        compare_flag   <= compare_flag_next;
        reload_value   <= reload_value_next;
        compare_value  <= compare_value_next;
        count_value    <= count_value_next;
        prescale_count <= prescale_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_data         <= read_data_next;
      interrupt_request <= compare_flag_next && control_next[CTRL_OCIEN_BIT];
    end
  end

  // A held result always reflects the current state, since state only moves
  // when a new item is accepted.
  a_irq_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (interrupt_request == (compare_flag && control[CTRL_OCIEN_BIT])))
    else $error("interrupt_request does not match flag and enable");

  // A status write with bit 0 set clears the flag.
  a_flag_clear: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (func == FUNC_WRITE) && (reg_select == REG_STATUS)
     && write_data[STAT_FLAG_BIT]) |=> !compare_flag)
    else $error("compare flag not cleared by status write");

  // A tick while disabled leaves counter and prescaler alone.
  a_disabled_tick: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (func == FUNC_TICK) && !control[CTRL_EN_BIT])
    |=> ($stable(count_value) && $stable(prescale_count)))
    else $error("counter moved while disabled");

  // No state change without an accepted item.
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> ($stable(count_value) && $stable(control) && $stable(compare_flag)))
    else $error("state changed without an item");

endmodule

`default_nettype wire
